// ===== sv/heading_pd_turn_step_macros.svh =====
// ----------------------------------------------------------------------------
// Heading PD turn step: assertion macros
// Shared concurrent assertion forms, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef HEADING_PD_TURN_STEP_MACROS_SVH
`define HEADING_PD_TURN_STEP_MACROS_SVH

// Checked only while out of reset.
`define HPTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define HPTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/hpts_pkg.sv =====
// ----------------------------------------------------------------------------
// Heading PD turn step package
// Register types, stage payloads and fixed constants of the turn controller.
// ----------------------------------------------------------------------------
package hpts_pkg;

  // Register indexes on the configuration port (byte address is 4 * index).
  typedef enum logic [2:0] {
    IDX_TARGET_HEADING   = 3'd0,
    IDX_PROP_GAIN        = 3'd1,
    IDX_DERIV_GAIN       = 3'd2,
    IDX_SLOW_SPEED_LIMIT = 3'd3,
    IDX_SETTLE_TICKS     = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] target_heading;
    logic [15:0] prop_gain;
    logic [15:0] deriv_gain;
    logic [9:0]  slow_speed_limit;
    logic [4:0]  settle_ticks;
  } cfg_t;

  localparam logic [15:0] TARGET_RST = 16'd0;
  localparam logic [15:0] PROP_RST   = 16'd422;
  localparam logic [15:0] DERIV_RST  = 16'd453;
  localparam logic [9:0]  SLOW_RST   = 10'd20;
  localparam logic [4:0]  SETTLE_RST = 5'd25;

  // Angles in hundredths of a degree.
  localparam logic [15:0]        FULL_TURN   = 16'd36000;
  localparam logic signed [17:0] FULL_TURN_S = 18'sd36000;
  localparam logic signed [17:0] HALF_TURN_S = 18'sd18000;
  localparam logic [14:0]        INNER_BAND  = 15'd50;
  localparam logic [14:0]        OUTER_BAND  = 15'd150;
  localparam logic signed [37:0] ROUND_HALF  = 38'sd128;
  localparam logic signed [37:0] OUT_LIMIT   = 38'sd18000;
  localparam logic [4:0]         COUNT_MAX   = 5'd31;

  // Payload between the error stage and the drive stage.
  typedef struct packed {
    logic signed [32:0] prop_prod;
    logic signed [33:0] deriv_prod;
    logic               boost;
    logic               stop;
    logic               settled;
    logic signed [15:0] err;
  } mid_t;

endpackage

// ===== sv/heading_pd_turn_step.sv =====
// ----------------------------------------------------------------------------
// Heading PD turn step
// One control tick of a turn-in-place PD heading controller.
// ----------------------------------------------------------------------------
// Usage: each request on the in_ channel carries one control tick (restart
// flag, measured heading, mean wheel speed). The block returns one request on
// the out_ channel per tick, in order: left and right drive, the wrapped
// heading error and the settled flag.
// A request is taken at an edge where in_valid is high and in_stall is low.
// The pipeline has three registers: input, gain products and result. A request
// passes through them in that order. While out_stall is low one request can be
// taken on every cycle; the sustained rate is then one tick per clock, as every
// stage can hand its request on in the cycle that it takes a new one.
// The loop state (last error, settle count) is updated as a tick leaves the
// input register, so consecutive ticks see each other's state.
// When the receiver raises out_stall the result holds, the stages behind it
// fill, and in_stall rises only once the input register has nowhere to go.
// Reset (rst_n low, synchronous) empties the pipeline, clears the state and
// loads the register defaults. Registers must be written over the APB-style
// port only while the block is idle; it is not enforced. pready is always high.
// ----------------------------------------------------------------------------
`include "heading_pd_turn_step_macros.svh"

module heading_pd_turn_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_restart,
  input  logic [15:0]        in_heading,
  input  logic [9:0]         in_mean_speed,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [16:0] out_drive_left,
  output logic signed [16:0] out_drive_right,
  output logic signed [15:0] out_heading_error,
  output logic               out_settled
);
  import hpts_pkg::*;

  cfg_t cfg;
  mid_t mid;

  logic        s0_valid_r, s0_valid_nxt;
  logic        s1_valid_r, s1_valid_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        s0_restart_r;
  logic [15:0] s0_heading_r;
  logic [9:0]  s0_mean_speed_r;

  logic out_free, s1_free, s0_free;
  logic s1_move, s0_move, in_take;

  assign pready = 1'b1;

  hpts_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // A stage may move on when the one ahead is empty or moving itself.
  always_comb begin
    out_free = !out_valid_r || !out_stall;
    s1_move  = s1_valid_r && out_free;
    s1_free  = !s1_valid_r || out_free;
    s0_move  = s0_valid_r && s1_free;
    s0_free  = !s0_valid_r || s1_free;
    in_take  = in_valid && s0_free;

    s0_valid_nxt  = in_take || (s0_valid_r && !s0_move);
    s1_valid_nxt  = s0_move || (s1_valid_r && !s1_move);
    out_valid_nxt = s1_move || (out_valid_r && !out_free);
  end

  assign in_stall  = !s0_free;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s0_valid_r  <= s0_valid_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s0_restart_r    <= in_restart;
      s0_heading_r    <= in_heading;
      s0_mean_speed_r <= in_mean_speed;
    end
  end

  hpts_error_stage u_err (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (s0_move),
    .cfg        (cfg),
    .restart    (s0_restart_r),
    .heading    (s0_heading_r),
    .mean_speed (s0_mean_speed_r),
    .mid        (mid)
  );

  hpts_drive_stage u_drive (
    .clk           (clk),
    .load          (s1_move),
    .mid           (mid),
    .drive_left    (out_drive_left),
    .drive_right   (out_drive_right),
    .heading_error (out_heading_error),
    .settled       (out_settled)
  );

  `HPTS_ASSERT(a_right_mirrors_left, out_valid |-> (out_drive_right == -out_drive_left), "right drive is not the negated left drive")
  `HPTS_ASSERT(a_settled_is_stopped, (out_valid && out_settled) |-> (out_drive_left == 17'sd0), "settled result carries a non-zero drive")
  `HPTS_ASSERT(a_settled_in_band, (out_valid && out_settled) |-> (out_heading_error < 16'sd50 && out_heading_error > -16'sd50), "settled result outside the half-degree band")
  `HPTS_ASSERT(a_error_range, out_valid |-> (out_heading_error >= -16'sd18000 && out_heading_error < 16'sd18000), "heading error outside one half turn")
  `HPTS_ASSERT(a_stall_needs_item, in_stall |-> (s0_valid_r && s1_valid_r && out_valid_r && out_stall), "input stalled while the pipeline has room")
  `HPTS_ASSERT_ALWAYS(a_empty_after_reset, $past(!rst_n) |-> !out_valid, "result valid directly after reset")

endmodule

// ===== sv/hpts_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Heading PD turn step: configuration registers
// APB-style register file holding target, gains and settle thresholds.
// ----------------------------------------------------------------------------
module hpts_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output hpts_pkg::cfg_t cfg
);
  import hpts_pkg::*;

  cfg_t     cfg_r;
  cfg_idx_t idx;
  logic     wr_en;

  assign idx   = cfg_idx_t'(paddr[4:2]);
  assign wr_en = psel && penable && pwrite;
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_heading   <= TARGET_RST;
      cfg_r.prop_gain        <= PROP_RST;
      cfg_r.deriv_gain       <= DERIV_RST;
      cfg_r.slow_speed_limit <= SLOW_RST;
      cfg_r.settle_ticks     <= SETTLE_RST;
    end else if (wr_en) begin
      unique case (idx)
        IDX_TARGET_HEADING:   cfg_r.target_heading   <= pwdata[15:0];
        IDX_PROP_GAIN:        cfg_r.prop_gain        <= pwdata[15:0];
        IDX_DERIV_GAIN:       cfg_r.deriv_gain       <= pwdata[15:0];
        IDX_SLOW_SPEED_LIMIT: cfg_r.slow_speed_limit <= pwdata[9:0];
        IDX_SETTLE_TICKS:     cfg_r.settle_ticks     <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      IDX_TARGET_HEADING:   prdata = {16'd0, cfg_r.target_heading};
      IDX_PROP_GAIN:        prdata = {16'd0, cfg_r.prop_gain};
      IDX_DERIV_GAIN:       prdata = {16'd0, cfg_r.deriv_gain};
      IDX_SLOW_SPEED_LIMIT: prdata = {22'd0, cfg_r.slow_speed_limit};
      IDX_SETTLE_TICKS:     prdata = {27'd0, cfg_r.settle_ticks};
      default:              prdata = 32'd0;
    endcase
  end

endmodule

// ===== sv/hpts_error_stage.sv =====
// ----------------------------------------------------------------------------
// Heading PD turn step: error stage
// Wraps the heading error, updates the loop state and forms the gain products.
// ----------------------------------------------------------------------------
module hpts_error_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  hpts_pkg::cfg_t     cfg,
  input  logic               restart,
  input  logic [15:0]        heading,
  input  logic [9:0]         mean_speed,
  output hpts_pkg::mid_t     mid
);
  import hpts_pkg::*;

  logic signed [15:0] last_error_r, last_error_nxt;
  logic [4:0]         settle_count_r, settle_count_nxt;
  mid_t               mid_r, mid_nxt;

  logic [15:0]        head_mod, tgt_mod;
  logic signed [17:0] diff, wrapped;
  logic signed [15:0] err, last_base;
  logic signed [16:0] err_delta;
  logic [14:0]        mag;
  logic [4:0]         count_base;
  logic               stop;

  always_comb begin
    // Both angles are below twice a full turn, so one subtraction reduces them.
    head_mod = (heading >= FULL_TURN) ? heading - FULL_TURN : heading;
    tgt_mod  = (cfg.target_heading >= FULL_TURN) ?
               cfg.target_heading - FULL_TURN : cfg.target_heading;
    diff = $signed({2'b00, tgt_mod}) - $signed({2'b00, head_mod});
    priority if (diff >= HALF_TURN_S) begin
      wrapped = diff - FULL_TURN_S;
    end else if (diff < -HALF_TURN_S) begin
      wrapped = diff + FULL_TURN_S;
    end else begin
      wrapped = diff;
    end
    err = wrapped[15:0];
    mag = err[15] ? 15'(-err) : 15'(err);

    last_base  = restart ? 16'sd0 : last_error_r;
    count_base = restart ? 5'd0 : settle_count_r;
    err_delta  = 17'(err) - 17'(last_base);

    stop = (mag < INNER_BAND) && (mean_speed < cfg.slow_speed_limit);
    if (stop) begin
      settle_count_nxt = (count_base < COUNT_MAX) ? count_base + 5'd1 : COUNT_MAX;
    end else begin
      settle_count_nxt = 5'd0;
    end
    last_error_nxt = err;

    mid_nxt.prop_prod  = $signed({1'b0, cfg.prop_gain}) * err;
    mid_nxt.deriv_prod = $signed({1'b0, cfg.deriv_gain}) * err_delta;
    mid_nxt.boost      = (mag > INNER_BAND) && (mag < OUTER_BAND);
    mid_nxt.stop       = stop;
    mid_nxt.settled    = stop && (settle_count_nxt >= cfg.settle_ticks);
    mid_nxt.err        = err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_error_r   <= 16'sd0;
      settle_count_r <= 5'd0;
    end else if (load) begin
      last_error_r   <= last_error_nxt;
      settle_count_r <= settle_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mid_r <= mid_nxt;
    end
  end

  assign mid = mid_r;

endmodule

// ===== sv/hpts_drive_stage.sv =====
// ----------------------------------------------------------------------------
// Heading PD turn step: drive stage
// Sums, boosts, rounds and clamps (or zeroes on stop) the PD command and scales it to wheel drive.
// ----------------------------------------------------------------------------
module hpts_drive_stage (
  input  logic               clk,
  input  logic               load,
  input  hpts_pkg::mid_t     mid,
  output logic signed [16:0] drive_left,
  output logic signed [16:0] drive_right,
  output logic signed [15:0] heading_error,
  output logic               settled
);
  import hpts_pkg::*;

  logic signed [37:0] acc, boosted, rounded;
  logic signed [15:0] cmd;
  logic signed [16:0] cmd_ext;
  logic signed [16:0] drive_left_r, drive_left_nxt;
  logic signed [16:0] drive_right_r, drive_right_nxt;
  logic signed [15:0] heading_error_r;
  logic               settled_r;

  always_comb begin
    acc     = 38'(mid.prop_prod) + 38'(mid.deriv_prod);
    boosted = mid.boost ? (acc <<< 2) + acc : acc;
    // Round to nearest with ties upwards; the arithmetic shift floors.
    rounded = (boosted + ROUND_HALF) >>> 8;
    priority if (mid.stop) begin
      cmd = 16'sd0;
    end else if (rounded > OUT_LIMIT) begin
      cmd = 16'(OUT_LIMIT);
    end else if (rounded < -OUT_LIMIT) begin
      cmd = 16'(-OUT_LIMIT);
    end else begin
      cmd = rounded[15:0];
    end
    cmd_ext         = 17'(cmd);
    drive_left_nxt  = (cmd_ext <<< 1) + cmd_ext;
    drive_right_nxt = -drive_left_nxt;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      drive_left_r    <= drive_left_nxt;
      drive_right_r   <= drive_right_nxt;
      heading_error_r <= mid.err;
      settled_r       <= mid.settled;
    end
  end

  assign drive_left    = drive_left_r;
  assign drive_right   = drive_right_r;
  assign heading_error = heading_error_r;
  assign settled       = settled_r;

endmodule

// ===== test/hpts_checker.sv =====
// ----------------------------------------------------------------------------
// Heading PD turn step: result checker
// Watches the register port and both request channels, predicts each control
// tick's drive command and compares every returned request field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpts_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_restart,
  input  logic [15:0]        in_heading,
  input  logic [9:0]         in_mean_speed,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [16:0] out_drive_left,
  input  logic signed [16:0] out_drive_right,
  input  logic signed [15:0] out_heading_error,
  input  logic               out_settled,
  output int                 mismatches,
  output int                 pending,
  output int                 checked,
  output int                 settled_seen
);
  import hpts_pkg::*;

  localparam int CIRCLE      = 36000;
  localparam int HALF_CIRCLE = 18000;
  localparam int NEAR_BAND   = 50;
  localparam int BOOST_BAND  = 150;
  localparam int BOOST_GAIN  = 5;
  localparam int CMD_CLAMP   = 18000;
  localparam int DRIVE_SCALE = 3;
  localparam int Q8_HALF     = 128;

  typedef struct packed {
    logic signed [16:0] left_cmd;
    logic signed [16:0] right_cmd;
    logic signed [15:0] err;
    logic               settled;
  } drive_cmd_t;

  cfg_t       cfg_copy;
  int         last_err;
  logic [4:0] settle_cnt;
  drive_cmd_t drive_cmds[$];
  int         err_count = 0;
  int         n_checked = 0;
  int         n_settled = 0;

  initial begin
    mismatches   = 0;
    pending      = 0;
    checked      = 0;
    settled_seen = 0;
  end

  // One control tick: wrapped error, PD sum with the boost-band boost, then the
  // settle logic, which overrides the command, and the clamp.
  function automatic drive_cmd_t predict_tick(input logic restart, input logic [15:0] heading,
                                              input logic [9:0] speed);
    drive_cmd_t cmd;
    int         err;
    int         mag;
    int         head_mod;
    int         tgt_mod;
    longint     acc;
    longint     u;
    longint     neg_u;
    logic       stop;
    if (restart) begin
      last_err   = 0;
      settle_cnt = '0;
    end
    head_mod = heading % CIRCLE;
    tgt_mod  = cfg_copy.target_heading % CIRCLE;
    err = tgt_mod - head_mod;
    if (err >= HALF_CIRCLE) begin
      err -= CIRCLE;
    end else if (err < -HALF_CIRCLE) begin
      err += CIRCLE;
    end
    mag = (err < 0) ? -err : err;
    acc = longint'(cfg_copy.prop_gain) * err + longint'(cfg_copy.deriv_gain) * (err - last_err);
    if (mag > NEAR_BAND && mag < BOOST_BAND) begin
      acc = acc * BOOST_GAIN;
    end
    // Round to nearest with ties upwards: an arithmetic shift floors.
    u = (acc + Q8_HALF) >>> 8;
    stop = (mag < NEAR_BAND) && (speed < cfg_copy.slow_speed_limit);
    if (stop) begin
      u = 0;
      if (settle_cnt != 5'h1f) begin
        settle_cnt = settle_cnt + 5'd1;
      end
    end else begin
      settle_cnt = '0;
    end
    cmd.settled = stop && (settle_cnt >= cfg_copy.settle_ticks);
    if (u > CMD_CLAMP) begin
      u = CMD_CLAMP;
    end else if (u < -CMD_CLAMP) begin
      u = -CMD_CLAMP;
    end
    u = u * DRIVE_SCALE;
    neg_u = -u;
    cmd.left_cmd  = u[16:0];
    cmd.right_cmd = neg_u[16:0];
    cmd.err       = err[15:0];
    last_err = err;
    return cmd;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("hpts_checker: %s wrong on result %0d: got %0d, expected %0d",
             what, n_checked, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin
    drive_cmd_t want;
    if (!rst_n) begin
      cfg_copy.target_heading   = TARGET_RST;
      cfg_copy.prop_gain        = PROP_RST;
      cfg_copy.deriv_gain       = DERIV_RST;
      cfg_copy.slow_speed_limit = SLOW_RST;
      cfg_copy.settle_ticks     = SETTLE_RST;
      last_err   = 0;
      settle_cnt = '0;
      drive_cmds.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (cfg_idx_t'(paddr[4:2]))
          IDX_TARGET_HEADING:   cfg_copy.target_heading   = pwdata[15:0];
          IDX_PROP_GAIN:        cfg_copy.prop_gain        = pwdata[15:0];
          IDX_DERIV_GAIN:       cfg_copy.deriv_gain       = pwdata[15:0];
          IDX_SLOW_SPEED_LIMIT: cfg_copy.slow_speed_limit = pwdata[9:0];
          IDX_SETTLE_TICKS:     cfg_copy.settle_ticks     = pwdata[4:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        drive_cmds.push_back(predict_tick(in_restart, in_heading, in_mean_speed));
      end
      if (out_valid && !out_stall) begin
        if (drive_cmds.size() == 0) begin
          report_mismatch("results outstanding", 64'sd1, 64'sd0);
        end else begin
          want = drive_cmds.pop_front();
          if (out_drive_left !== want.left_cmd)
            report_mismatch("drive_left", longint'(out_drive_left),
                            longint'(want.left_cmd));
          if (out_drive_right !== want.right_cmd)
            report_mismatch("drive_right", longint'(out_drive_right),
                            longint'(want.right_cmd));
          if (out_heading_error !== want.err)
            report_mismatch("heading_error", longint'(out_heading_error),
                            longint'(want.err));
          if (out_settled !== want.settled)
            report_mismatch("settled", longint'(out_settled), longint'(want.settled));
          if (want.settled) n_settled++;
        end
        n_checked++;
      end
    end
    mismatches   <= err_count;
    pending      <= drive_cmds.size();
    checked      <= n_checked;
    settled_seen <= n_settled;
  end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// Heading PD turn step: testbench top
// Drives control ticks and register settings into the turn controller with
// random idling on both channels and a long receiver hold-off, and leaves all
// prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import hpts_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASES        = 12;
  localparam int PHASE_TICKS   = 150;
  localparam int LONG_HOLD     = 80;
  localparam int HOLD_PHASE    = 6;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_restart = 1'b0;
  logic [15:0]        in_heading = '0;
  logic [9:0]         in_mean_speed = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [16:0] out_drive_left;
  logic signed [16:0] out_drive_right;
  logic signed [15:0] out_heading_error;
  logic               out_settled;

  int mismatches;
  int pending;
  int checked;
  int settled_seen;

  int          cycle_count = 0;
  int          ticks_sent = 0;
  int          settings_used = 0;
  int          hold_asked = 0;
  int          hold_done = 0;
  logic        no_idle = 1'b0;
  logic [15:0] cur_target = TARGET_RST;
  logic [9:0]  cur_slow = SLOW_RST;

  always #6 clk = ~clk;

  heading_pd_turn_step dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_restart        (in_restart),
    .in_heading        (in_heading),
    .in_mean_speed     (in_mean_speed),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_drive_left    (out_drive_left),
    .out_drive_right   (out_drive_right),
    .out_heading_error (out_heading_error),
    .out_settled       (out_settled)
  );

  hpts_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_restart        (in_restart),
    .in_heading        (in_heading),
    .in_mean_speed     (in_mean_speed),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_drive_left    (out_drive_left),
    .out_drive_right   (out_drive_right),
    .out_heading_error (out_heading_error),
    .out_settled       (out_settled),
    .mismatches        (mismatches),
    .pending           (pending),
    .checked           (checked),
    .settled_seen      (settled_seen)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: timed out with %0d results outstanding", pending);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Result side: a random pause before each request, no pause in the no-idle
  // phases, and one long hold-off when the stimulus asks for it.
  initial begin : result_sink
    int unsigned pause;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_done != hold_asked) begin
        hold_done++;
        pause = LONG_HOLD;
      end else begin
        pause = no_idle ? 0 : $urandom_range(0, 13);
      end
      if (pause != 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // One register write; the port is then left idle before the task returns.
  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == IDX_TARGET_HEADING) cur_target = value[15:0];
    if (idx == IDX_SLOW_SPEED_LIMIT) cur_slow = value[9:0];
    @(posedge clk);
  endtask

  task automatic send_tick(input logic restart, input logic [15:0] heading,
                           input logic [9:0] speed);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_restart    <= restart;
    in_heading    <= heading;
    in_mean_speed <= speed;
    do @(posedge clk); while (in_stall);
    ticks_sent++;
  endtask

  // Lets every outstanding result come back before the registers change.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // A heading a given offset from the target, now and then given as its
  // out-of-range alias one full turn higher.
  function automatic logic [15:0] heading_near(input int offset);
    int h;
    h = int'(cur_target % 16'd36000) + offset;
    while (h < 0) h += 36000;
    h = h % 36000;
    if (h + 36000 <= 65535 && $urandom_range(0, 7) == 0) h += 36000;
    return h[15:0];
  endfunction

  function automatic logic [9:0] slow_speed;
    if (cur_slow == 0) return '0;
    if ($urandom_range(0, 11) == 0) return cur_slow;
    return 10'($urandom_range(0, cur_slow - 1));
  endfunction

  task automatic configure_phase(input int phase);
    logic [15:0] tgt;
    logic [15:0] kp;
    logic [15:0] kd;
    logic [9:0]  slow;
    logic [4:0]  ticks;
    case (phase)
      0: begin
        tgt = 16'd9000; kp = 16'd422; kd = 16'd453; slow = 10'd20; ticks = 5'd25;
      end
      1: begin
        tgt = 16'd0; kp = 16'd0; kd = 16'd0; slow = 10'd0; ticks = 5'd1;
      end
      2: begin
        tgt = 16'd35999; kp = 16'hffff; kd = 16'hffff; slow = 10'd600; ticks = 5'd31;
      end
      3: begin
        tgt = 16'hffff; kp = 16'd256; kd = 16'd0; slow = 10'h3ff; ticks = 5'd0;
      end
      4: begin
        tgt = 16'd36000; kp = 16'd0; kd = 16'hffff; slow = 10'd300; ticks = 5'd5;
      end
      default: begin
        tgt = 16'(($urandom_range(0, 7) == 0) ? $urandom_range(36000, 65535)
                                              : $urandom_range(0, 35999));
        kp = 16'($urandom_range(0, 1) ? $urandom_range(0, 1023) : $urandom_range(0, 65535));
        kd = 16'($urandom_range(0, 1) ? $urandom_range(0, 1023) : $urandom_range(0, 65535));
        slow  = 10'($urandom_range(0, 600));
        ticks = 5'($urandom_range(0, 31));
      end
    endcase
    write_reg(IDX_TARGET_HEADING, 32'(tgt));
    write_reg(IDX_PROP_GAIN, 32'(kp));
    write_reg(IDX_DERIV_GAIN, 32'(kd));
    write_reg(IDX_SLOW_SPEED_LIMIT, 32'(slow));
    write_reg(IDX_SETTLE_TICKS, 32'(ticks));
    settings_used++;
  endtask

  // Mostly well-formed turns: runs that sit in the target band while slow
  // (to drive the settle count up to saturation) and approaches that close in
  // on the target through the boost band, with random ticks mixed in.
  task automatic run_phase(input int unsigned n_ticks);
    int unsigned sent;
    int unsigned kind;
    int unsigned len;
    int          offset;
    logic [9:0]  speed;
    sent = 0;
    while (sent < n_ticks) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        len = $urandom_range(20, 40);
        for (int i = 0; i < len; i++) begin
          offset = int'($urandom_range(0, 98)) - 49;
          if ($urandom_range(0, 15) == 0) offset = $urandom_range(0, 1) ? 50 : -50;
          send_tick((i == 0) && $urandom_range(0, 1), heading_near(offset), slow_speed());
        end
      end else if (kind < 7) begin
        len    = $urandom_range(5, 15);
        offset = int'($urandom_range(0, 36000)) - 18000;
        speed  = 10'($urandom_range(0, 600));
        for (int i = 0; i < len; i++) begin
          send_tick((i == 0) && $urandom_range(0, 3) == 0, heading_near(offset), speed);
          offset = offset * int'($urandom_range(1, 3)) / 4 + int'($urandom_range(0, 40)) - 20;
          speed  = speed >> 1;
        end
      end else begin
        len = 1;
        send_tick(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                  10'($urandom_range(0, 1023)));
      end
      sent += len;
    end
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: target zero, so the heading alone sets the error.
    send_tick(1'b1, 16'd0, 10'd0);
    send_tick(1'b0, 16'd18000, 10'd0);
    send_tick(1'b0, 16'd18001, 10'd600);
    send_tick(1'b0, 16'd17999, 10'h3ff);
    send_tick(1'b0, 16'hffff, 10'd0);
    send_tick(1'b0, 16'd36000, 10'd0);
    send_tick(1'b0, 16'd35999, 10'd19);
    send_tick(1'b0, 16'd35999, 10'd20);
    send_tick(1'b0, 16'd35950, 10'd0);
    send_tick(1'b0, 16'd35949, 10'd0);
    send_tick(1'b0, 16'd35851, 10'd0);
    send_tick(1'b0, 16'd35850, 10'd0);
    send_tick(1'b0, 16'd50, 10'd0);
    send_tick(1'b0, 16'd100, 10'd5);
    send_tick(1'b0, 16'd1, 10'd0);
    send_tick(1'b1, 16'd0, 10'd0);
    send_tick(1'b0, 16'h5555, 10'h2aa);
    send_tick(1'b0, 16'haaaa, 10'h155);
    send_tick(1'b0, 16'h8000, 10'h200);
    drain();
    // With no settle ticks required every slow in-band tick is settled.
    write_reg(IDX_SETTLE_TICKS, 32'd0);
    send_tick(1'b1, 16'd0, 10'd0);
    send_tick(1'b0, 16'd10, 10'd3);
    send_tick(1'b0, 16'd35990, 10'd0);
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      configure_phase(phase);
      no_idle = (phase % 3 == 2) || (phase == HOLD_PHASE);
      if (phase == HOLD_PHASE) hold_asked++;
      run_phase(PHASE_TICKS);
      drain();
    end

    $display("tb_top: %0d control ticks over %0d register settings, %0d results compared",
             ticks_sent, settings_used + 1, checked);
    $display("tb_top: %0d settled results seen, one long receiver hold-off applied",
             settled_seen);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
